@@ rtl/ehbe_pkg.sv @@
`timescale 1ns / 1ps

package ehbe_pkg;

  localparam int MAX_LOG2    = 8;
  localparam int MIN_LOG2    = 3;
  localparam int BLK_BITS    = 1 << MAX_LOG2;
  localparam int BLK_BYTES   = BLK_BITS / 8;
  localparam int POS_W       = MAX_LOG2;
  localparam int BIDX_W      = MAX_LOG2 - 3;
  localparam int LOG2_W      = 4;

  localparam logic [POS_W-1:0]  START_POS    = POS_W'(3);
  localparam logic [POS_W:0]    START_PARITY = (POS_W+1)'(4);
  localparam logic [LOG2_W-1:0] RESET_LOG2   = LOG2_W'(MAX_LOG2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SEND
  } ehbe_state_t;

endpackage

@@ rtl/ehbe_ram.sv @@
`timescale 1ns / 1ps

module ehbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/extended_hamming_block_encoder_unit.sv @@
`timescale 1ns / 1ps
// Extended Hamming (SECDED) block encoder, one message bit per input item.
// Input: one item per cycle while idle; data bits never stall the block.
// The item that completes (or flushes) a block moves the FSM through FETCH and LOAD to SEND.
// Each output byte passes through RAM fetch, load and send; no input is taken until the
//   last byte of the block is taken, and an output stall holds the FSM in send.
// Reset (rst_n low, synchronous): block_log2 returns to 8, the partial block is dropped.

module extended_hamming_block_encoder_unit
  import ehbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [0] data_bit, [7:1] zero
  input  logic              in_tuser,   // [0] cmd (1 = flush)
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_byte
  output logic              out_tlast,  // last_byte
  // configuration
  input  logic              cfg_wr_en,
  input  logic [LOG2_W-1:0] cfg_wr_data // block_log2
);

  ehbe_state_t state_r, state_nxt;

  logic [LOG2_W-1:0] log2_r, log2_nxt;
  logic [POS_W-1:0]  wpos_r, wpos_nxt;     // next data position
  logic [POS_W:0]    npp_r, npp_nxt;       // next power-of-two position to skip
  logic [POS_W-1:0]  syn_r, syn_nxt;       // running XOR of set-bit positions
  logic              par_r, par_nxt;       // running parity of data bits
  logic [7:0]        asm_r, asm_nxt;       // byte under assembly
  logic [BIDX_W:0]   fill_r, fill_nxt;     // bytes already written to the RAM
  logic [BIDX_W-1:0] k_r, k_nxt;           // readout byte index
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic [LOG2_W-1:0] eff_log2;
  logic [POS_W:0]    blk_len;
  logic [POS_W:0]    pos_inc;
  logic [BIDX_W:0]   nbytes;
  logic [BIDX_W-1:0] last_idx;
  logic              last_k;
  logic              in_acc, is_data, is_flush, blk_full, start_read, byte_end;
  logic              dbit;
  logic [7:0]        asm_set;
  logic [7:0]        ram_rdata;
  logic [7:0]        src_byte;
  logic [7:0]        enc_byte;

  // Saturate the rate register to the supported range; the register keeps raw bits.
  always_comb begin
    priority if (log2_r < LOG2_W'(MIN_LOG2)) begin
      eff_log2 = LOG2_W'(MIN_LOG2);
    end else if (log2_r > LOG2_W'(MAX_LOG2)) begin
      eff_log2 = LOG2_W'(MAX_LOG2);
    end else begin
      eff_log2 = log2_r;
    end
  end

  assign blk_len  = (POS_W+1)'(1) << eff_log2;
  assign nbytes   = (BIDX_W+1)'(1) << (eff_log2 - LOG2_W'(MIN_LOG2));
  assign last_idx = BIDX_W'(nbytes - (BIDX_W+1)'(1));
  assign last_k   = (k_r == last_idx);

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign dbit       = in_tdata[0];
  assign is_data    = in_acc & ~in_tuser;
  assign is_flush   = in_acc & in_tuser & (wpos_r != START_POS);
  assign pos_inc    = {1'b0, wpos_r} + (POS_W+1)'(1);
  assign blk_full   = is_data & (pos_inc == blk_len);
  assign start_read = blk_full | is_flush;
  // Parity positions sit at bit 0 of a byte or inside byte 0, so a byte always
  // closes on its bit 7.
  assign byte_end   = is_data & (wpos_r[2:0] == 3'd7);

  always_comb begin
    asm_set = asm_r;
    asm_set[wpos_r[2:0]] = dbit;
  end

  ehbe_ram #(
    .WIDTH (8),
    .DEPTH (BLK_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (byte_end),
    .waddr (wpos_r[POS_W-1:3]),
    .wdata (asm_set),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  // Pick the stored byte, the byte still under assembly, or zero padding, then
  // insert the parity bits.
  always_comb begin
    priority if ({1'b0, k_r} < fill_r) begin
      src_byte = ram_rdata;
    end else if ({1'b0, k_r} == fill_r) begin
      src_byte = asm_r;
    end else begin
      src_byte = 8'd0;
    end
    enc_byte = src_byte;
    if (k_r == BIDX_W'(0)) begin
      enc_byte[0] = par_r ^ (^syn_r);
      enc_byte[1] = syn_r[0];
      enc_byte[2] = syn_r[1];
      enc_byte[4] = syn_r[2];
    end
    for (int j = 0; j < BIDX_W; j++) begin
      if (k_r == BIDX_W'(1 << j)) begin
        enc_byte[0] = syn_r[3+j];
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start_read) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_tready) begin
          state_nxt = last_k ? ST_IDLE : ST_FETCH;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    log2_nxt     = log2_r;
    wpos_nxt     = wpos_r;
    npp_nxt      = npp_r;
    syn_nxt      = syn_r;
    par_nxt      = par_r;
    asm_nxt      = asm_r;
    fill_nxt     = fill_r;
    k_nxt        = k_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;

    if (cfg_wr_en) begin
      // Rate change: drop any partial block.
      log2_nxt = cfg_wr_data;
      wpos_nxt = START_POS;
      npp_nxt  = START_PARITY;
      syn_nxt  = '0;
      par_nxt  = 1'b0;
      asm_nxt  = '0;
      fill_nxt = '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (is_data) begin
            syn_nxt = syn_r ^ (dbit ? wpos_r : POS_W'(0));
            par_nxt = par_r ^ dbit;
            if (byte_end) begin
              asm_nxt  = '0;
              fill_nxt = fill_r + (BIDX_W+1)'(1);
            end else begin
              asm_nxt  = asm_set;
            end
            if (!blk_full) begin
              // Skip the next parity position.
              if (pos_inc == npp_r) begin
                wpos_nxt = pos_inc[POS_W-1:0] + POS_W'(1);
                npp_nxt  = npp_r << 1;
              end else begin
                wpos_nxt = pos_inc[POS_W-1:0];
              end
            end
          end
          if (start_read) begin
            k_nxt = '0;
          end
        end
        ST_FETCH: ;
        ST_LOAD: begin
          out_byte_nxt = enc_byte;
          out_last_nxt = last_k;
        end
        ST_SEND: begin
          if (out_tready) begin
            if (last_k) begin
              wpos_nxt = START_POS;
              npp_nxt  = START_PARITY;
              syn_nxt  = '0;
              par_nxt  = 1'b0;
              asm_nxt  = '0;
              fill_nxt = '0;
            end else begin
              k_nxt = k_r + BIDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = (state_r == ST_SEND);
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      log2_r  <= RESET_LOG2;
      wpos_r  <= START_POS;
      npp_r   <= START_PARITY;
      syn_r   <= '0;
      par_r   <= 1'b0;
      asm_r   <= '0;
      fill_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      log2_r  <= log2_nxt;
      wpos_r  <= wpos_nxt;
      npp_r   <= npp_nxt;
      syn_r   <= syn_nxt;
      par_r   <= par_nxt;
      asm_r   <= asm_nxt;
      fill_r  <= fill_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
